// ----- rtl/jtc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// jtc_pkg: shared types and constants of the journal transaction controller
// Field widths, operation, status, command and register codes, and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package jtc_pkg;

   localparam int CNT_W      = 5;
   localparam int BLK_W      = 20;
   localparam int OP_W       = 2;
   localparam int STAT_W     = 3;
   localparam int CMD_W      = 2;
   localparam int NEED_W     = 12;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 48;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int KIND_W     = 3;

   localparam logic [CNT_W-1:0] OPEN_MAX = 5'd31;

   // operation codes
   localparam logic [OP_W-1:0] OP_BEGIN = 2'd0;
   localparam logic [OP_W-1:0] OP_END   = 2'd1;
   localparam logic [OP_W-1:0] OP_LOG   = 2'd2;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
   localparam logic [STAT_W-1:0] ST_WAIT     = 3'd1;
   localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
   localparam logic [STAT_W-1:0] ST_OUTSIDE  = 3'd3;
   localparam logic [STAT_W-1:0] ST_NO_BEGIN = 3'd4;

   // disk command codes
   localparam logic [CMD_W-1:0] CMD_NONE   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_COPY   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_HEADER = 2'd2;

   // kinds of beat the datapath can load into its output register
   localparam logic [KIND_W-1:0] EMIT_RESP      = 3'd0;
   localparam logic [KIND_W-1:0] EMIT_COPY_OUT  = 3'd1;
   localparam logic [KIND_W-1:0] EMIT_COPY_BACK = 3'd2;
   localparam logic [KIND_W-1:0] EMIT_HDR_COUNT = 3'd3;
   localparam logic [KIND_W-1:0] EMIT_HDR_ZERO  = 3'd4;

   // register indexes (paddr bit 2)
   localparam logic REG_LOG_START     = 1'b0;
   localparam logic REG_MAX_OP_BLOCKS = 1'b1;

   typedef struct packed {
      logic               load_req;
      logic               idx_clr;
      logic               idx_inc;
      logic               rd_en;
      logic               open_inc;
      logic               open_dec;
      logic               append;
      logic               entry_clr;
      logic               emit;
      logic [KIND_W-1:0]  emit_kind;
      logic [STAT_W-1:0]  emit_status;
   } jtc_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            begin_ok;
      logic            open_zero;
      logic            open_one;
      logic            entry_zero;
      logic            table_full;
      logic            idx_end;
      logic            hit;
      logic            out_free;
   } jtc_stat_type;

endpackage
`default_nettype wire

// ----- rtl/jtc_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// jtc_ctrl: sequencer of the journal transaction controller
// Takes one request at a time, walks the table for searches and commits,
// and tells the datapath when to read, update and emit a beat.
// ----------------------------------------------------------------------------
module jtc_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   input  jtc_pkg::jtc_stat_type stat,
   output jtc_pkg::jtc_cmd_type  cmd
);
   import jtc_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DECODE   = 4'd1;
   localparam logic [3:0] S_SRCH_RD  = 4'd2;
   localparam logic [3:0] S_SRCH_CMP = 4'd3;
   localparam logic [3:0] S_C1_RD    = 4'd4;
   localparam logic [3:0] S_C1_EM    = 4'd5;
   localparam logic [3:0] S_HDR1     = 4'd6;
   localparam logic [3:0] S_C2_RD    = 4'd7;
   localparam logic [3:0] S_C2_EM    = 4'd8;
   localparam logic [3:0] S_HDR2     = 4'd9;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.op)
               OP_BEGIN: begin
                  if (stat.out_free) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_kind   = EMIT_RESP;
                     cmd.emit_status = stat.begin_ok ? ST_OK : ST_WAIT;
                     cmd.open_inc    = stat.begin_ok;
                     state_in        = S_IDLE;
                  end
               end
               OP_END: begin
                  if (stat.open_zero) begin
                     if (stat.out_free) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_kind   = EMIT_RESP;
                        cmd.emit_status = ST_NO_BEGIN;
                        state_in        = S_IDLE;
                     end
                  end else if (stat.open_one && !stat.entry_zero) begin
                     // last operation closes with logged blocks: commit
                     cmd.open_dec = 1'b1;
                     cmd.idx_clr  = 1'b1;
                     state_in     = S_C1_RD;
                  end else if (stat.out_free) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_kind   = EMIT_RESP;
                     cmd.emit_status = ST_OK;
                     cmd.open_dec    = 1'b1;
                     state_in        = S_IDLE;
                  end
               end
               OP_LOG: begin
                  if (stat.table_full || stat.open_zero) begin
                     if (stat.out_free) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_kind   = EMIT_RESP;
                        cmd.emit_status = stat.table_full ? ST_FULL : ST_OUTSIDE;
                        state_in        = S_IDLE;
                     end
                  end else begin
                     cmd.idx_clr = 1'b1;
                     state_in    = S_SRCH_RD;
                  end
               end
               default: begin
                  if (stat.out_free) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_kind   = EMIT_RESP;
                     cmd.emit_status = ST_OK;
                     state_in        = S_IDLE;
                  end
               end
            endcase
         end
         S_SRCH_RD: begin
            if (stat.idx_end) begin
               // not found: append at the end of the table
               if (stat.out_free) begin
                  cmd.append      = 1'b1;
                  cmd.emit        = 1'b1;
                  cmd.emit_kind   = EMIT_RESP;
                  cmd.emit_status = ST_OK;
                  state_in        = S_IDLE;
               end
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_SRCH_CMP;
            end
         end
         S_SRCH_CMP: begin
            if (stat.hit) begin
               if (stat.out_free) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_kind   = EMIT_RESP;
                  cmd.emit_status = ST_OK;
                  state_in        = S_IDLE;
               end
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_SRCH_RD;
            end
         end
         S_C1_RD: begin
            if (stat.idx_end) begin
               state_in = S_HDR1;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_C1_EM;
            end
         end
         S_C1_EM: begin
            if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = EMIT_COPY_OUT;
               cmd.idx_inc   = 1'b1;
               state_in      = S_C1_RD;
            end
         end
         S_HDR1: begin
            if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = EMIT_HDR_COUNT;
               cmd.idx_clr   = 1'b1;
               state_in      = S_C2_RD;
            end
         end
         S_C2_RD: begin
            if (stat.idx_end) begin
               state_in = S_HDR2;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_C2_EM;
            end
         end
         S_C2_EM: begin
            if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = EMIT_COPY_BACK;
               cmd.idx_inc   = 1'b1;
               state_in      = S_C2_RD;
            end
         end
         S_HDR2: begin
            if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = EMIT_HDR_ZERO;
               cmd.entry_clr = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/jtc_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// jtc_dp: datapath of the journal transaction controller
// Holds the registers, the counters, the logged-block table and the output
// register, and reports flags to the sequencer.
// ----------------------------------------------------------------------------
module jtc_dp #(
   parameter int LOG_ENTRIES = 30
) (
   input  wire                                clock,
   input  wire                                reset,
   input  jtc_pkg::jtc_cmd_type               cmd,
   output jtc_pkg::jtc_stat_type              stat,
   input  wire [jtc_pkg::OP_W-1:0]            req_op,
   input  wire [jtc_pkg::BLK_W-1:0]           req_blk,
   input  wire                                csr_psel,
   input  wire                                csr_penable,
   input  wire                                csr_pwrite,
   input  wire [jtc_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire [jtc_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [jtc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [jtc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [jtc_pkg::CMD_W-1:0]          rsp_tuser,
   output logic                               rsp_tlast
);
   import jtc_pkg::*;

   localparam int IDX_W = (LOG_ENTRIES > 1) ? $clog2(LOG_ENTRIES) : 1;

   logic [BLK_W-1:0]  log_start_ff, log_start_in;
   logic [CNT_W-1:0]  max_op_ff, max_op_in;
   logic [CNT_W-1:0]  open_ff, open_in;
   logic [CNT_W-1:0]  entry_ff, entry_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [BLK_W-1:0]  blk_ff, blk_in;
   logic [BLK_W-1:0]  rd_data_ff;
   logic [BLK_W-1:0]  log_mem [LOG_ENTRIES];

   logic              out_valid_ff, out_valid_in;
   logic [STAT_W-1:0] out_status_ff, out_status_in;
   logic [CMD_W-1:0]  out_cmd_ff, out_cmd_in;
   logic [BLK_W-1:0]  out_src_ff, out_src_in;
   logic [BLK_W-1:0]  out_dst_ff, out_dst_in;
   logic [CNT_W-1:0]  out_hdr_ff, out_hdr_in;
   logic              out_last_ff, out_last_in;

   logic              csr_wr;
   logic [CNT_W:0]    open_plus;
   logic [NEED_W-1:0] need;
   logic [BLK_W-1:0]  slot_blk;
   logic              out_free;

   assign csr_wr    = csr_psel & csr_penable & csr_pwrite;
   assign open_plus = {1'b0, open_ff} + {{CNT_W{1'b0}}, 1'b1};
   assign need      = NEED_W'(entry_ff) + NEED_W'(open_plus) * NEED_W'(max_op_ff);
   assign slot_blk  = log_start_ff + BLK_W'(idx_ff) + BLK_W'(1);
   assign out_free  = !out_valid_ff || rsp_tready;

   always_comb begin
      stat.op         = op_ff;
      stat.begin_ok   = (open_ff != OPEN_MAX) && (need <= NEED_W'(LOG_ENTRIES));
      stat.open_zero  = (open_ff == '0);
      stat.open_one   = (open_ff == CNT_W'(1));
      stat.entry_zero = (entry_ff == '0);
      stat.table_full = (entry_ff >= CNT_W'(LOG_ENTRIES));
      stat.idx_end    = (idx_ff == entry_ff);
      stat.hit        = (rd_data_ff == blk_ff);
      stat.out_free   = out_free;
   end

   always_comb begin
      csr_prdata = '0;
      case (csr_paddr[2])
         REG_LOG_START:     csr_prdata = CSR_DATA_W'(log_start_ff);
         REG_MAX_OP_BLOCKS: csr_prdata = CSR_DATA_W'(max_op_ff);
         default:           csr_prdata = '0;
      endcase
   end

   always_comb begin
      log_start_in = log_start_ff;
      max_op_in    = max_op_ff;
      if (csr_wr && csr_paddr[2] == REG_LOG_START) begin
         log_start_in = csr_pwdata[BLK_W-1:0];
      end
      if (csr_wr && csr_paddr[2] == REG_MAX_OP_BLOCKS) begin
         max_op_in = csr_pwdata[CNT_W-1:0];
      end

      open_in = open_ff;
      if (cmd.open_inc) begin
         open_in = open_ff + CNT_W'(1);
      end else if (cmd.open_dec) begin
         open_in = open_ff - CNT_W'(1);
      end

      entry_in = entry_ff;
      if (cmd.entry_clr) begin
         entry_in = '0;
      end else if (cmd.append) begin
         entry_in = entry_ff + CNT_W'(1);
      end

      idx_in = idx_ff;
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + CNT_W'(1);
      end

      op_in  = cmd.load_req ? req_op  : op_ff;
      blk_in = cmd.load_req ? req_blk : blk_ff;
   end

   always_comb begin
      out_valid_in  = out_valid_ff & ~rsp_tready;
      out_status_in = out_status_ff;
      out_cmd_in    = out_cmd_ff;
      out_src_in    = out_src_ff;
      out_dst_in    = out_dst_ff;
      out_hdr_in    = out_hdr_ff;
      out_last_in   = out_last_ff;
      if (cmd.emit) begin
         out_valid_in  = 1'b1;
         out_status_in = ST_OK;
         out_cmd_in    = CMD_NONE;
         out_src_in    = '0;
         out_dst_in    = '0;
         out_hdr_in    = '0;
         out_last_in   = 1'b0;
         case (cmd.emit_kind)
            EMIT_RESP: begin
               out_status_in = cmd.emit_status;
               out_last_in   = 1'b1;
            end
            EMIT_COPY_OUT: begin
               out_cmd_in = CMD_COPY;
               out_src_in = rd_data_ff;
               out_dst_in = slot_blk;
            end
            EMIT_COPY_BACK: begin
               out_cmd_in = CMD_COPY;
               out_src_in = slot_blk;
               out_dst_in = rd_data_ff;
            end
            EMIT_HDR_COUNT: begin
               out_cmd_in = CMD_HEADER;
               out_hdr_in = entry_ff;
            end
            EMIT_HDR_ZERO: begin
               out_cmd_in  = CMD_HEADER;
               out_last_in = 1'b1;
            end
            default: begin
               out_last_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         log_start_ff <= BLK_W'(2);
         max_op_ff    <= CNT_W'(10);
         open_ff      <= '0;
         entry_ff     <= '0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         log_start_ff <= log_start_in;
         max_op_ff    <= max_op_in;
         open_ff      <= open_in;
         entry_ff     <= entry_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      blk_ff        <= blk_in;
      out_status_ff <= out_status_in;
      out_cmd_ff    <= out_cmd_in;
      out_src_ff    <= out_src_in;
      out_dst_ff    <= out_dst_in;
      out_hdr_ff    <= out_hdr_in;
      out_last_ff   <= out_last_in;
   end

   // logged-block table: one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.append) begin
         log_mem[entry_ff[IDX_W-1:0]] <= blk_ff;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= log_mem[idx_ff[IDX_W-1:0]];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_hdr_ff, out_dst_ff, out_src_ff, out_status_ff};
   assign rsp_tuser  = out_cmd_ff;
   assign rsp_tlast  = out_last_ff;

`ifndef ASSERT_OFF
   a_entry_bound: assert property (@(posedge clock) disable iff (reset)
      entry_ff <= CNT_W'(LOG_ENTRIES))
      else $error("entry count beyond table depth");

   a_append_at_end: assert property (@(posedge clock) disable iff (reset)
      cmd.append |-> (idx_ff == entry_ff) && (entry_ff < CNT_W'(LOG_ENTRIES)))
      else $error("append away from table end");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free)
      else $error("beat loaded over an untaken beat");

   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.entry_clr |=> (entry_ff == '0) && (open_ff == '0))
      else $error("table not empty after commit");
`endif

endmodule
`default_nettype wire

// ----- rtl/journal_transaction_controller.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// journal_transaction_controller: redo journal with write absorption
// Requests arrive on req_*: req_tuser carries the operation (begin, end,
// log a written block), req_tdata the block number. Each request gives a run
// of beats on rsp_*, closed by rsp_tlast; rsp_tuser is the disk command.
// A request is taken only while the sequencer is idle. Begin, end without
// commit, errors and unknown codes answer one registered beat from the decode state.
// A log-write reads the table one entry at a time, a read state then a
// compare state per entry. A commit emits 2*n+2 beats for n logged blocks,
// each table copy reading its entry before its beat (one table read port).
// Registers sit on csr_* (APB): log_start at 0x0, max_op_blocks at 0x4.
// Reset gives log_start 2, max_op_blocks 10 and an empty transaction.
// A stalled rsp_tready holds the output register and each emitting state;
// one new request may still be taken while the last beat waits.
// ----------------------------------------------------------------------------
module journal_transaction_controller #(
   parameter int LOG_ENTRIES = 30
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire [jtc_pkg::REQ_DATA_W-1:0]     req_tdata,  // block_number[19:0]
   input  wire [jtc_pkg::OP_W-1:0]           req_tuser,  // operation[1:0]
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   // status[2:0], source_block[22:3], target_block[42:23], header_count[47:43]
   output logic [jtc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [jtc_pkg::CMD_W-1:0]         rsp_tuser,  // command[1:0]
   output logic                              rsp_tlast,
   input  wire                               csr_psel,
   input  wire                               csr_penable,
   input  wire                               csr_pwrite,
   input  wire [jtc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire [jtc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [jtc_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import jtc_pkg::*;

   jtc_cmd_type  cmd;
   jtc_stat_type stat;

   assign csr_pready = 1'b1;

   jtc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   jtc_dp #(
      .LOG_ENTRIES (LOG_ENTRIES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_op      (req_tuser),
      .req_blk     (req_tdata[BLK_W-1:0]),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule
`default_nettype wire
